>>> hdl/jsu_pkg.sv
// Shared types and codes for the JSON string unescaper.
// Parse phases, result status codes and the controller/datapath bundles.
// No dependencies.
package jsu_pkg;

  typedef enum logic [2:0] {
    PH_SEEK,
    PH_STR,
    PH_ESC,
    PH_HEX,
    PH_IDLE
  } phase_t;

  localparam logic [1:0] ST_DATA  = 2'd0;
  localparam logic [1:0] ST_DONE  = 2'd1;
  localparam logic [1:0] ST_ERROR = 2'd2;

  // Outcome of feeding one byte through the parser
  typedef struct packed {
    phase_t          phase;
    logic [15:0]     code_point;
    logic [2:0]      hex_seen;
    logic            held_we;
    logic [1:0]      held_addr;
    logic [1:0]      data_count;
    logic [2:0][7:0] data;
    logic [1:0]      fin_status;
    logic            replay_start;
    logic [1:0]      replay_count;
  } step_t;

  typedef struct packed {
    logic step_input;
    logic step_replay;
    logic pop;
  } jsu_cmd_t;

  typedef struct packed {
    logic buf_empty;
    logic replay_pending;
  } jsu_stat_t;

endpackage

>>> hdl/jsu_decode.sv
// Byte decoder: next parse state and result bytes for one fed byte.
// Pure combinational; uses jsu_pkg.
module jsu_decode (
  input  jsu_pkg::phase_t phase,
  input  logic [15:0]     code_point,
  input  logic [2:0]      hex_seen,
  input  logic [7:0]      text_byte,
  input  logic            last,
  input  logic            replay,
  output jsu_pkg::step_t  step
);
  import jsu_pkg::*;

  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_N     = 8'h6E;
  localparam logic [7:0] CH_R     = 8'h72;
  localparam logic [7:0] CH_T     = 8'h74;
  localparam logic [7:0] CH_B     = 8'h62;
  localparam logic [7:0] CH_F     = 8'h66;
  localparam logic [7:0] CH_U     = 8'h75;
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_FF    = 8'h0C;

  localparam logic [7:0] LEAD2    = 8'hC0;
  localparam logic [7:0] LEAD3    = 8'hE0;
  localparam logic [7:0] CONT     = 8'h80;

  function automatic logic [3:0] hex_val(input logic [7:0] h);
    logic [7:0] d;
    begin
      d = 8'h00;
      if (h inside {[8'h30:8'h39]}) begin
        d = h - 8'h30;
      end else if (h inside {[8'h61:8'h66]}) begin
        d = h - 8'h57;
      end else if (h inside {[8'h41:8'h46]}) begin
        d = h - 8'h37;
      end
      return d[3:0];
    end
  endfunction

  logic [15:0] cp_shift;
  logic [2:0]  hex_inc;

  assign cp_shift = {code_point[11:0], hex_val(text_byte)};
  assign hex_inc  = hex_seen + 3'd1;

  always_comb begin
    step              = '0;
    step.phase        = phase;
    step.code_point   = code_point;
    step.hex_seen     = hex_seen;
    step.held_addr    = hex_seen[1:0];

    case (phase)
      PH_SEEK: begin
        if (text_byte inside {CH_SP, CH_TAB, CH_CR, CH_LF}) begin
          if (last) step.fin_status = ST_ERROR;
        end else if (text_byte == CH_QUOTE) begin
          step.phase = PH_STR;
          if (last) step.fin_status = ST_ERROR;
        end else begin
          step.fin_status = ST_ERROR;
        end
      end
      PH_STR: begin
        if (text_byte == CH_QUOTE) begin
          step.fin_status = ST_DONE;
        end else if (text_byte == CH_BSL) begin
          if (last) begin
            step.data[0]    = CH_BSL;
            step.data_count = 2'd1;
            step.fin_status = ST_ERROR;
          end else begin
            step.phase = PH_ESC;
          end
        end else begin
          step.data[0]    = text_byte;
          step.data_count = 2'd1;
          if (last) step.fin_status = ST_ERROR;
        end
      end
      PH_ESC: begin
        step.phase      = PH_STR;
        step.data_count = 2'd1;
        case (text_byte)
          CH_N:    step.data[0] = CH_LF;
          CH_R:    step.data[0] = CH_CR;
          CH_T:    step.data[0] = CH_TAB;
          CH_B:    step.data[0] = CH_BS;
          CH_F:    step.data[0] = CH_FF;
          CH_U:    step.data_count = 2'd0;
          default: step.data[0] = text_byte;
        endcase
        if (text_byte == CH_U && !last && !replay) begin
          step.phase      = PH_HEX;
          step.code_point = '0;
          step.hex_seen   = '0;
        end else if (last) begin
          step.fin_status = ST_ERROR;
        end
      end
      PH_HEX: begin
        step.held_we    = 1'b1;
        step.code_point = cp_shift;
        if (hex_inc[2]) begin
          step.phase    = PH_STR;
          step.hex_seen = '0;
          if (cp_shift[15:7] == '0) begin
            step.data[0]    = cp_shift[7:0];
            step.data_count = 2'd1;
          end else if (cp_shift[15:11] == '0) begin
            step.data[0]    = LEAD2 | {3'b000, cp_shift[10:6]};
            step.data[1]    = CONT | {2'b00, cp_shift[5:0]};
            step.data_count = 2'd2;
          end else begin
            step.data[0]    = LEAD3 | {4'h0, cp_shift[15:12]};
            step.data[1]    = CONT | {2'b00, cp_shift[11:6]};
            step.data[2]    = CONT | {2'b00, cp_shift[5:0]};
            step.data_count = 2'd3;
          end
          if (last) step.fin_status = ST_ERROR;
        end else if (last) begin
          // short escape: drop the u, replay what was held
          step.phase        = PH_STR;
          step.hex_seen     = '0;
          step.replay_start = 1'b1;
          step.replay_count = hex_inc[1:0];
        end else begin
          step.hex_seen = hex_inc;
        end
      end
      default: begin
      end
    endcase

    if (step.fin_status != ST_DATA) step.phase = PH_IDLE;
  end

endmodule

>>> hdl/jsu_datapath.sv
// Datapath: parse registers, held hex bytes, result queue and output register.
// Uses jsu_pkg and jsu_decode; driven by jsu_ctrl commands.
module jsu_datapath (
  input  logic               clk,
  input  logic               rst,
  input  jsu_pkg::jsu_cmd_t  cmd,
  output jsu_pkg::jsu_stat_t stat,
  input  logic [7:0]         text_byte,
  input  logic               end_of_text,
  output logic [7:0]         out_byte,
  output logic [1:0]         status,
  output logic               run_last
);
  import jsu_pkg::*;

  typedef struct packed {
    logic [7:0] data;
    logic [1:0] status;
  } entry_t;

  phase_t      phase;
  logic [15:0] code_point;
  logic [2:0]  hex_seen;
  logic [7:0]  held [4];
  logic [1:0]  rp_left;
  logic [1:0]  rp_idx;
  logic        item_last;
  entry_t      entries [4];
  logic [2:0]  entry_count;
  logic        step_final;

  step_t       dec;
  logic        step_en;
  logic [7:0]  feed_byte;
  logic        feed_last;
  logic        final_now;
  logic        text_end;
  entry_t      load [4];
  logic [2:0]  load_count;

  assign step_en   = cmd.step_input | cmd.step_replay;
  assign feed_byte = cmd.step_replay ? held[rp_idx] : text_byte;
  assign feed_last = cmd.step_replay ? (rp_left == 2'd1) : end_of_text;

  jsu_decode u_decode (
    .phase      (phase),
    .code_point (code_point),
    .hex_seen   (hex_seen),
    .text_byte  (feed_byte),
    .last       (feed_last),
    .replay     (cmd.step_replay),
    .step       (dec)
  );

  // a step is final when nothing more of this request will be replayed
  assign final_now = cmd.step_replay ? (feed_last || dec.phase == PH_IDLE)
                                     : !dec.replay_start;
  assign text_end  = (cmd.step_replay ? item_last : end_of_text) && final_now;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      load[i] = (3'(i) < {1'b0, dec.data_count}) ? {dec.data[i], ST_DATA} : '0;
    end
    load[3] = '0;
    if (dec.fin_status != ST_DATA) load[dec.data_count] = {8'h00, dec.fin_status};
    load_count = {1'b0, dec.data_count} + {2'b00, dec.fin_status != ST_DATA};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_SEEK;
      code_point  <= '0;
      hex_seen    <= '0;
      rp_left     <= '0;
      rp_idx      <= '0;
      item_last   <= 1'b0;
      entry_count <= '0;
      step_final  <= 1'b0;
    end else if (step_en) begin
      if (text_end) begin
        phase      <= PH_SEEK;
        code_point <= '0;
        hex_seen   <= '0;
      end else begin
        phase      <= dec.phase;
        code_point <= dec.code_point;
        hex_seen   <= dec.hex_seen;
      end
      entry_count <= load_count;
      step_final  <= final_now;
      if (cmd.step_input) item_last <= end_of_text;
      if (dec.replay_start) begin
        rp_left <= dec.replay_count;
        rp_idx  <= '0;
      end else if (cmd.step_replay) begin
        rp_left <= final_now ? 2'd0 : rp_left - 2'd1;
        rp_idx  <= rp_idx + 2'd1;
      end
    end else if (cmd.pop) begin
      entry_count <= entry_count - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en && dec.held_we) held[dec.held_addr] <= feed_byte;
    if (step_en) begin
      entries <= load;
    end else if (cmd.pop) begin
      for (int i = 0; i < 3; i++) entries[i] <= entries[i + 1];
    end
    if (cmd.pop) begin
      out_byte <= entries[0].data;
      status   <= entries[0].status;
      run_last <= (entry_count == 3'd1) && step_final;
    end
  end

  assign stat.buf_empty      = (entry_count == 3'd0);
  assign stat.replay_pending = (rp_left != 2'd0);

`ifndef SYNTH
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    entry_count <= 3'd4)
    else $error("result queue count out of range");

  a_replay_phase: assert property (@(posedge clk) disable iff (rst)
    (rp_left != 2'd0) |-> (phase != PH_HEX))
    else $error("hex escape open during replay");
`endif

endmodule

>>> hdl/jsu_ctrl.sv
// Controller: takes requests, drains the result queue, sequences replay.
// Uses jsu_pkg; commands jsu_datapath.
module jsu_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               text_valid,
  output logic               text_stall,
  output logic               result_valid,
  input  logic               result_stall,
  input  jsu_pkg::jsu_stat_t stat,
  output jsu_pkg::jsu_cmd_t  cmd
);
  import jsu_pkg::*;

  typedef enum logic {
    S_WAIT,
    S_EMIT
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_free;

  assign out_free   = !result_valid || !result_stall;
  assign text_stall = (state != S_WAIT);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_WAIT: begin
        if (text_valid) begin
          cmd.step_input = 1'b1;
          state_next     = S_EMIT;
        end
      end
      S_EMIT: begin
        if (!stat.buf_empty) begin
          cmd.pop = out_free;
        end else if (stat.replay_pending) begin
          cmd.step_replay = 1'b1;
        end else begin
          state_next = S_WAIT;
        end
      end
      default: state_next = S_WAIT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_WAIT;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      result_valid <= cmd.pop | (result_valid & result_stall);
    end
  end

`ifndef SYNTH
  a_no_step_pop: assert property (@(posedge clk) disable iff (rst)
    !(cmd.pop && (cmd.step_input || cmd.step_replay)))
    else $error("step and pop in the same cycle");

  a_pop_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.pop |=> result_valid)
    else $error("popped result not presented");

  a_ready_clean: assert property (@(posedge clk) disable iff (rst)
    !text_stall |-> (stat.buf_empty && !stat.replay_pending))
    else $error("request taken with work pending");
`endif

endmodule

>>> hdl/json_string_unescaper.sv
// Top level of the JSON string unescaper.
// Instantiates jsu_ctrl and jsu_datapath; uses jsu_pkg.
//
// Decodes one quoted JSON string per text, one text byte per request, and
// returns decoded bytes followed by a done or error status. The block works
// on one request at a time: the accepting cycle runs the byte through the
// decoder into a four-entry result queue, then each result leaves through the
// output register, waiting while result_stall is high, and once the queue is
// empty the controller returns to taking requests. When a text ends inside a
// \u escape, the one to three held bytes are fed back through the same
// decoder one at a time, each followed by its results.
module json_string_unescaper (
  input  logic       clk,
  input  logic       rst,
  input  logic       text_valid,
  output logic       text_stall,
  input  logic [7:0] text_byte,
  input  logic       end_of_text,
  output logic       result_valid,
  input  logic       result_stall,
  output logic [7:0] out_byte,
  output logic [1:0] status,
  output logic       run_last
);
  import jsu_pkg::*;

  jsu_cmd_t  cmd;
  jsu_stat_t stat;

  jsu_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .text_valid   (text_valid),
    .text_stall   (text_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .stat         (stat),
    .cmd          (cmd)
  );

  jsu_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .text_byte   (text_byte),
    .end_of_text (end_of_text),
    .out_byte    (out_byte),
    .status      (status),
    .run_last    (run_last)
  );

endmodule
